FILE: rtl/vector3_normalize_assert.svh
// assertion macros for the vector normalizer
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define V3N_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define V3N_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/v3n_pkg.sv
// shared widths, latency figures and lane types of the vector normalizer
package v3n_pkg;

  // component and fraction widths
  localparam int IN_WIDTH  = 16;
  localparam int FRAC_BITS = 14;
  localparam int NUM_LANES = 3;

  // datapath widths
  localparam int MAG_W  = IN_WIDTH;
  localparam int SQ_W   = 2 * IN_WIDTH;
  localparam int SUM_W  = 2 * IN_WIDTH;
  localparam int ROOT_W = IN_WIDTH;
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int OUT_W  = FRAC_BITS + 2;

  // magnitude hold from the square stage until the root is ready
  localparam int ALIGN_DLY = ROOT_W + 2;
  // magnitude, square, sum, root stages, divider stages, output stage
  localparam int PIPE_LAT  = 4 + ROOT_W + QUO_W;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((NUM_LANES * IN_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NUM_LANES * OUT_W + 1 + 7) / 8) * 8;
  localparam int ZERO_BIT  = NUM_LANES * OUT_W;

  // side info that travels with each lane through the divider
  typedef struct packed {
    logic neg;
    logic zero;
  } lane_tag_t;

endpackage

FILE: rtl/v3n_sq_lane.sv
// front of one component lane: magnitude, square and magnitude hold
module v3n_sq_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [v3n_pkg::IN_WIDTH-1:0] comp_i,
  output logic [v3n_pkg::SQ_W-1:0]           sq_o,
  output logic [v3n_pkg::MAG_W-1:0]          mag_o,
  output logic                               neg_o
);

  logic [v3n_pkg::MAG_W-1:0] mag_a_q;
  logic [v3n_pkg::MAG_W-1:0] mag_a_d;
  logic                      neg_a_q;
  logic [v3n_pkg::SQ_W-1:0]  sq_q;
  logic [v3n_pkg::MAG_W-1:0] mag_dly_q [v3n_pkg::ALIGN_DLY];
  logic                      neg_dly_q [v3n_pkg::ALIGN_DLY];

  // sign and magnitude, most negative value keeps its exact magnitude
  always_comb begin
    if (comp_i[v3n_pkg::IN_WIDTH-1]) begin
      mag_a_d = v3n_pkg::MAG_W'(~comp_i + 1'b1);
    end else begin
      mag_a_d = v3n_pkg::MAG_W'(comp_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_a_d;
      neg_a_q <= comp_i[v3n_pkg::IN_WIDTH-1];
    end
  end

  // square stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= v3n_pkg::SQ_W'(mag_a_q) * v3n_pkg::SQ_W'(mag_a_q);
    end
  end

  // hold magnitude and sign while the sum and root are formed
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_dly_q[0] <= mag_a_q;
      neg_dly_q[0] <= neg_a_q;
      for (int k = 1; k < v3n_pkg::ALIGN_DLY; k++) begin
        mag_dly_q[k] <= mag_dly_q[k-1];
        neg_dly_q[k] <= neg_dly_q[k-1];
      end
    end
  end

  assign sq_o  = sq_q;
  assign mag_o = mag_dly_q[v3n_pkg::ALIGN_DLY-1];
  assign neg_o = neg_dly_q[v3n_pkg::ALIGN_DLY-1];

endmodule

FILE: rtl/v3n_isqrt.sv
// pipelined integer square root, one root bit per stage
module v3n_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [v3n_pkg::SUM_W-1:0]    sum_i,
  output logic [v3n_pkg::ROOT_W-1:0]   root_o
);

  logic [v3n_pkg::SUM_W-1:0]  rem_q  [v3n_pkg::ROOT_W-1];
  logic [v3n_pkg::ROOT_W-1:0] root_q [v3n_pkg::ROOT_W];

  for (genvar s = 0; s < v3n_pkg::ROOT_W; s++) begin : g_stage
    localparam int B = v3n_pkg::ROOT_W - 1 - s;

    logic [v3n_pkg::SUM_W-1:0]  rem_in;
    logic [v3n_pkg::ROOT_W-1:0] rt_in;
    logic [v3n_pkg::SUM_W:0]    trial;
    logic                       take;

    // operands from the previous stage
    if (s == 0) begin : g_first
      assign rem_in = sum_i;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign rt_in  = root_q[s-1];
    end

    // (root + 2^B)^2 - root^2 against the remainder
    always_comb begin
      trial = ((v3n_pkg::SUM_W + 1)'(rt_in) << (B + 1))
            | ((v3n_pkg::SUM_W + 1)'(1) << (2 * B));
      take  = ({1'b0, rem_in} >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= take ? (rt_in | (v3n_pkg::ROOT_W'(1) << B)) : rt_in;
      end
    end

    // remainder is not needed after the last bit
    if (s < v3n_pkg::ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? (rem_in - trial[v3n_pkg::SUM_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[v3n_pkg::ROOT_W-1];

endmodule

FILE: rtl/v3n_div_lane.sv
// pipelined restoring divider of one lane, one quotient bit per stage
module v3n_div_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [v3n_pkg::MAG_W-1:0]      mag_i,
  input  logic [v3n_pkg::ROOT_W-1:0]     root_i,
  input  v3n_pkg::lane_tag_t             tag_i,
  output logic [v3n_pkg::QUO_W-1:0]      quo_o,
  output v3n_pkg::lane_tag_t             tag_o
);

  logic [v3n_pkg::DVD_W-1:0]  rem_q [v3n_pkg::QUO_W-1];
  logic [v3n_pkg::ROOT_W-1:0] dvs_q [v3n_pkg::QUO_W-1];
  logic [v3n_pkg::QUO_W-1:0]  quo_q [v3n_pkg::QUO_W];
  v3n_pkg::lane_tag_t         tag_q [v3n_pkg::QUO_W];

  for (genvar s = 0; s < v3n_pkg::QUO_W; s++) begin : g_stage
    localparam int J = v3n_pkg::QUO_W - 1 - s;

    logic [v3n_pkg::DVD_W-1:0]  rem_in;
    logic [v3n_pkg::ROOT_W-1:0] dvs_in;
    logic [v3n_pkg::QUO_W-1:0]  quo_in;
    v3n_pkg::lane_tag_t         tag_in;
    logic [v3n_pkg::DVD_W:0]    shifted;
    logic                       take;

    // operands from the previous stage, dividend is magnitude times 2^frac
    if (s == 0) begin : g_first
      assign rem_in = {mag_i, {v3n_pkg::FRAC_BITS{1'b0}}};
      assign dvs_in = root_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dvs_in = dvs_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      shifted = (v3n_pkg::DVD_W + 1)'(dvs_in) << J;
      take    = ({1'b0, rem_in} >= shifted);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= take ? (quo_in | (v3n_pkg::QUO_W'(1) << J)) : quo_in;
        tag_q[s] <= tag_in;
      end
    end

    // remainder and divisor are not needed after the last bit
    if (s < v3n_pkg::QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? (rem_in - shifted[v3n_pkg::DVD_W-1:0]) : rem_in;
          dvs_q[s] <= dvs_in;
        end
      end
    end
  end

  assign quo_o = quo_q[v3n_pkg::QUO_W-1];
  assign tag_o = tag_q[v3n_pkg::QUO_W-1];

endmodule

FILE: rtl/vector3_normalize.sv
// stages from input beat to output beat, all held while the output is stalled
// (2 lane front stages, 1 sum, 16 root stages, 15 divider stages, 1 output merge)
// throughput: one vector per cycle unless stalled; the root and lane dividers are fully
// pipelined; a one-beat skid register keeps tready registered while the output is stalled
// reset clears the skid flag and the stage valid bits only, data registers are not reset
module vector3_normalize (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // comp_x [15:0], comp_y [31:16], comp_z [47:32]
  input  logic [v3n_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // unit_x [15:0], unit_y [31:16], unit_z [47:32], zero_length [48], zero pad above
  output logic [v3n_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);

  `include "vector3_normalize_assert.svh"

  localparam int LANES = v3n_pkg::NUM_LANES;
  localparam int OUT_W = v3n_pkg::OUT_W;
  localparam int LAT   = v3n_pkg::PIPE_LAT;
  localparam logic signed [OUT_W-1:0] UnitOne = OUT_W'(1 << v3n_pkg::FRAC_BITS);

  logic                            en;
  logic                            in_vld;
  logic [v3n_pkg::S_TDATA_W-1:0]   in_data;
  logic                            skid_full_q;
  logic                            skid_full_d;
  logic [v3n_pkg::S_TDATA_W-1:0]   skid_data_q;
  logic [LAT-1:0]                  vld_q;
  logic [v3n_pkg::SUM_W-1:0]       sum_q;
  logic [v3n_pkg::ROOT_W-1:0]      root;
  logic [v3n_pkg::M_TDATA_W-1:0]   out_q;
  logic [v3n_pkg::M_TDATA_W-1:0]   out_d;
  logic [v3n_pkg::SQ_W-1:0]        sq     [LANES];
  logic [v3n_pkg::MAG_W-1:0]       mag    [LANES];
  logic                            neg    [LANES];
  logic [v3n_pkg::QUO_W-1:0]       quo    [LANES];
  v3n_pkg::lane_tag_t              tag_in [LANES];
  v3n_pkg::lane_tag_t              tag_out[LANES];
  logic [LANES-1:0]                unit_ok;

  // pipeline advances unless a finished beat is held at the output
  assign en = !vld_q[LAT-1] || m_axis_tready;

  // skid register catches one beat while the pipeline is held
  assign s_axis_tready = !skid_full_q;
  assign in_data       = skid_full_q ? skid_data_q : s_axis_tdata;
  assign in_vld        = skid_full_q || (s_axis_tvalid && s_axis_tready);

  always_comb begin
    skid_full_d = skid_full_q;
    if (en) begin
      skid_full_d = 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && s_axis_tvalid && s_axis_tready) begin
      skid_data_q <= s_axis_tdata;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_vld};
    end
  end

  // component lanes, front half
  for (genvar k = 0; k < LANES; k++) begin : g_front
    v3n_sq_lane u_sq_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .comp_i (in_data[k*v3n_pkg::IN_WIDTH +: v3n_pkg::IN_WIDTH]),
      .sq_o   (sq[k]),
      .mag_o  (mag[k]),
      .neg_o  (neg[k])
    );
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq[0] + sq[1] + sq[2];
    end
  end

  // shared magnitude root
  v3n_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_q),
    .root_o (root)
  );

  // component lanes, divider half
  for (genvar k = 0; k < LANES; k++) begin : g_div
    assign tag_in[k].neg  = neg[k];
    assign tag_in[k].zero = (root == '0);

    v3n_div_lane u_div_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (mag[k]),
      .root_i (root),
      .tag_i  (tag_in[k]),
      .quo_o  (quo[k]),
      .tag_o  (tag_out[k])
    );
  end

  // merge: sign restore, zero-vector override and packing
  always_comb begin
    logic [OUT_W-1:0] ext;
    out_d = '0;
    for (int k = 0; k < LANES; k++) begin
      ext = {1'b0, quo[k]};
      if (tag_out[0].zero) begin
        out_d[k*OUT_W +: OUT_W] = '0;
      end else if (tag_out[k].neg) begin
        out_d[k*OUT_W +: OUT_W] = ~ext + 1'b1;
      end else begin
        out_d[k*OUT_W +: OUT_W] = ext;
      end
    end
    out_d[v3n_pkg::ZERO_BIT] = tag_out[0].zero;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = vld_q[LAT-1];

  // each output component lies within plus or minus one
  for (genvar k = 0; k < LANES; k++) begin : g_range
    assign unit_ok[k] = ($signed(out_q[k*OUT_W +: OUT_W]) <= UnitOne)
                     && ($signed(out_q[k*OUT_W +: OUT_W]) >= -UnitOne);
  end

  // checks
  `V3N_ASSERT_IMP(a_zero_out, m_axis_tvalid && m_axis_tdata[v3n_pkg::ZERO_BIT], m_axis_tdata[v3n_pkg::ZERO_BIT-1:0] == '0, "zero vector gave nonzero components")
  `V3N_ASSERT_IMP(a_unit_range, m_axis_tvalid, &unit_ok, "unit component out of range")
  `V3N_ASSERT_NXT(a_skid_drain, en, !skid_full_q, "skid register kept a beat while running")

endmodule
